// ===== rtl/mst_pkg.sv =====
package mst_pkg;

   localparam int NUM_SLOTS_DEF    = 16;
   localparam int MAX_RESULTS      = 16;
   localparam logic [3:0] TIME_SCALE_RESET = 4'd10;

   localparam logic [1:0] CMD_TICK       = 2'd0;
   localparam logic [1:0] CMD_REGISTER   = 2'd1;
   localparam logic [1:0] CMD_UNREGISTER = 2'd2;

   localparam logic [2:0] KIND_REGISTERED = 3'd0;
   localparam logic [2:0] KIND_FULL       = 3'd1;
   localparam logic [2:0] KIND_FREED      = 3'd2;
   localparam logic [2:0] KIND_WAS_EMPTY  = 3'd3;
   localparam logic [2:0] KIND_BAD_INDEX  = 3'd4;
   localparam logic [2:0] KIND_FIRED      = 3'd5;
   localparam logic [2:0] KIND_TICK_NONE  = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] timeout;
      logic [15:0] period;
      logic [7:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  slot;
      logic [31:0] now_tick;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        active;
      logic [31:0] due;
      logic [31:0] reload;
   } slot_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] tick;
      logic [19:0] tmo_scaled;
      logic [19:0] per_scaled;
      logic        idx_hit;
      logic        fire_ok;
      logic        claim_ok;
   } head_ctl_type;

   typedef struct packed {
      logic fire;
      logic claim;
      logic freed;
   } head_evt_type;

endpackage

// ===== rtl/mst_cell.sv =====
module mst_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  mst_pkg::slot_type slot_d,
   output mst_pkg::slot_type slot_q
);

   logic        active_ff, active_in;
   logic [31:0] due_ff, due_in;
   logic [31:0] reload_ff, reload_in;

   always_comb begin
      active_in = shift ? slot_d.active : active_ff;
      due_in    = shift ? slot_d.due    : due_ff;
      reload_in = shift ? slot_d.reload : reload_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      due_ff    <= due_in;
      reload_ff <= reload_in;
   end

   assign slot_q.active = active_ff;
   assign slot_q.due    = due_ff;
   assign slot_q.reload = reload_ff;

endmodule

// ===== rtl/mst_head.sv =====
module mst_head (
   input  mst_pkg::slot_type     cur,
   input  mst_pkg::head_ctl_type ctl,
   output mst_pkg::slot_type     nxt,
   output mst_pkg::head_evt_type evt
);

   always_comb begin
      nxt = cur;
      evt = '0;
      case (ctl.cmd)
         mst_pkg::CMD_TICK: begin
            if (cur.active && (cur.due <= ctl.tick) && ctl.fire_ok) begin
               evt.fire = 1'b1;
               if (cur.reload != 32'd0) begin
                  nxt.due = ctl.tick + cur.reload;
               end else begin
                  nxt.active = 1'b0;
               end
            end
         end
         mst_pkg::CMD_REGISTER: begin
            // lowest free slot wins, later free slots see claim_ok low
            if (!cur.active && ctl.claim_ok) begin
               evt.claim  = 1'b1;
               nxt.active = 1'b1;
               nxt.due    = ctl.tick + 32'(ctl.tmo_scaled);
               nxt.reload = 32'(ctl.per_scaled);
            end
         end
         mst_pkg::CMD_UNREGISTER: begin
            if (cur.active && ctl.idx_hit) begin
               evt.freed  = 1'b1;
               nxt.active = 1'b0;
               nxt.reload = 32'd0;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== rtl/multi_slot_timer_pool_top.sv =====
// Timer slot pool built as a ring of slot cells that rotates past one processing head.
// Every tick, register or unregister command is accepted, then rotates the whole ring once
// through the head, then posts the final word; no new command is accepted until then.
// A tick that fires slots posts each fired word but the last during the rotation; the
// ring pauses while the output register holds a word that has not been taken and another
// must be posted. An unused command code is accepted at once, returns to idle and gives
// no word. The time scale register is written at once through csr_wr_en and csr_wr_data
// and is applied when a timer is registered.
module multi_slot_timer_pool_top #(
   parameter int NUM_SLOTS = mst_pkg::NUM_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mst_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mst_pkg::rsp_type rsp_word,
   input  logic             csr_wr_en,
   input  logic [3:0]       csr_wr_data
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(mst_pkg::MAX_RESULTS + 1);
   localparam logic [IW-1:0] LAST_STEP = IW'(NUM_SLOTS - 1);

   mst_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      step_ff, step_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [7:0]         idx_ff, idx_in;
   logic [19:0]        tmo_sc_ff, tmo_sc_in;
   logic [19:0]        per_sc_ff, per_sc_in;
   logic [31:0]        tick_ff, tick_in;
   logic [3:0]         scale_ff, scale_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [2:0]         pend_kind_ff, pend_kind_in;
   logic [5:0]         pend_slot_ff, pend_slot_in;
   logic [CW-1:0]      fire_cnt_ff, fire_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mst_pkg::rsp_type   rsp_ff, rsp_in;

   mst_pkg::slot_type     cell_q [NUM_SLOTS];
   mst_pkg::slot_type     head_nxt;
   mst_pkg::head_ctl_type head_ctl;
   mst_pkg::head_evt_type head_evt;

   logic accept;
   logic out_free;
   logic advance;
   logic push;
   mst_pkg::rsp_type push_word;

   assign req_ready = (state_ff == mst_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      head_ctl.cmd        = cmd_ff;
      head_ctl.tick       = tick_ff;
      head_ctl.tmo_scaled = tmo_sc_ff;
      head_ctl.per_scaled = per_sc_ff;
      head_ctl.idx_hit    = (idx_ff == 8'(step_ff));
      head_ctl.fire_ok    = (fire_cnt_ff < CW'(mst_pkg::MAX_RESULTS));
      head_ctl.claim_ok   = !pend_valid_ff;
   end

   mst_head u_head (
      .cur (cell_q[0]),
      .ctl (head_ctl),
      .nxt (head_nxt),
      .evt (head_evt)
   );

   // a new fire has to flush the held one first
   assign advance = (state_ff == mst_pkg::ST_SCAN) &&
                    !(head_evt.fire && pend_valid_ff && !out_free);

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      mst_pkg::slot_type cell_d;
      if (i == NUM_SLOTS - 1) begin : g_tail
         assign cell_d = head_nxt;
      end else begin : g_link
         assign cell_d = cell_q[i+1];
      end
      mst_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .shift  (advance),
         .slot_d (cell_d),
         .slot_q (cell_q[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      tmo_sc_in     = tmo_sc_ff;
      per_sc_in     = per_sc_ff;
      tick_in       = tick_ff;
      scale_in      = csr_wr_en ? csr_wr_data : scale_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_slot_in  = pend_slot_ff;
      fire_cnt_in   = fire_cnt_ff;
      push          = 1'b0;
      push_word     = '0;
      push_word.now_tick = tick_ff;

      unique case (state_ff)
         mst_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in        = req_word.cmd;
               idx_in        = req_word.slot_index;
               tmo_sc_in     = 20'(req_word.timeout) * 20'(scale_ff);
               per_sc_in     = 20'(req_word.period) * 20'(scale_ff);
               step_in       = '0;
               pend_valid_in = 1'b0;
               fire_cnt_in   = '0;
               case (req_word.cmd) inside
                  mst_pkg::CMD_TICK: begin
                     tick_in  = tick_ff + 32'd1;
                     state_in = mst_pkg::ST_SCAN;
                  end
                  mst_pkg::CMD_REGISTER, mst_pkg::CMD_UNREGISTER: begin
                     state_in = mst_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = mst_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         mst_pkg::ST_SCAN: begin
            if (advance) begin
               step_in = step_ff + IW'(1);
               if (step_ff == LAST_STEP) begin
                  state_in = mst_pkg::ST_DONE;
               end
               if (head_evt.fire) begin
                  if (pend_valid_ff) begin
                     push           = 1'b1;
                     push_word.kind = pend_kind_ff;
                     push_word.slot = pend_slot_ff;
                     push_word.last = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_kind_in  = mst_pkg::KIND_FIRED;
                  pend_slot_in  = 6'(step_ff);
                  fire_cnt_in   = fire_cnt_ff + CW'(1);
               end else if (head_evt.claim) begin
                  pend_valid_in = 1'b1;
                  pend_kind_in  = mst_pkg::KIND_REGISTERED;
                  pend_slot_in  = 6'(step_ff);
               end else if (head_evt.freed) begin
                  pend_valid_in = 1'b1;
                  pend_kind_in  = mst_pkg::KIND_FREED;
                  pend_slot_in  = 6'(step_ff);
               end
            end
         end
         mst_pkg::ST_DONE: begin
            if (out_free) begin
               push           = 1'b1;
               push_word.last = 1'b1;
               state_in       = mst_pkg::ST_IDLE;
               if (pend_valid_ff) begin
                  push_word.kind = pend_kind_ff;
                  push_word.slot = pend_slot_ff;
               end else begin
                  case (cmd_ff)
                     mst_pkg::CMD_TICK:     push_word.kind = mst_pkg::KIND_TICK_NONE;
                     mst_pkg::CMD_REGISTER: push_word.kind = mst_pkg::KIND_FULL;
                     default: begin
                        push_word.kind = (idx_ff >= 8'(NUM_SLOTS)) ?
                                         mst_pkg::KIND_BAD_INDEX : mst_pkg::KIND_WAS_EMPTY;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = mst_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = push ? push_word : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mst_pkg::ST_IDLE;
         step_ff       <= '0;
         tick_ff       <= 32'd0;
         scale_ff      <= mst_pkg::TIME_SCALE_RESET;
         pend_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         tick_ff       <= tick_in;
         scale_ff      <= scale_in;
         pend_valid_ff <= pend_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      tmo_sc_ff    <= tmo_sc_in;
      per_sc_ff    <= per_sc_in;
      pend_kind_ff <= pend_kind_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ===== rtl/mst_checker.sv =====
module mst_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mst_pkg::req_type req_word,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mst_pkg::rsp_type rsp_word
);

   // a held word stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // only fired words can be followed by more words of the same command
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.kind != mst_pkg::KIND_FIRED) |-> rsp_word.last)
      else $error("non-fired word without last");

   // slot is zero for kinds that name no slot
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.kind == mst_pkg::KIND_FULL ||
                    rsp_word.kind == mst_pkg::KIND_WAS_EMPTY ||
                    rsp_word.kind == mst_pkg::KIND_BAD_INDEX ||
                    rsp_word.kind == mst_pkg::KIND_TICK_NONE) |-> rsp_word.slot == 6'd0)
      else $error("slot not zero");

   // a real command keeps the request side closed while the ring turns
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_word.cmd == mst_pkg::CMD_TICK ||
                                 req_word.cmd == mst_pkg::CMD_REGISTER ||
                                 req_word.cmd == mst_pkg::CMD_UNREGISTER) |=> !req_ready)
      else $error("request taken during scan");

endmodule

bind multi_slot_timer_pool_top mst_checker u_mst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// ===== verif/tb_multi_slot_timer_pool_top.sv =====
`timescale 1ns / 100ps

module tb_multi_slot_timer_pool_top;

   localparam int POOL_SLOTS = mst_pkg::NUM_SLOTS_DEF;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mst_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   mst_pkg::rsp_type rsp_word;
   logic             csr_wr_en = 1'b0;
   logic [3:0]       csr_wr_data = 4'd0;

   multi_slot_timer_pool_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // timer pool mirror
   logic [31:0] tick_now;
   logic [3:0]  scale_now;
   logic        slot_live [POOL_SLOTS];
   logic [31:0] slot_due [POOL_SLOTS];
   logic [31:0] slot_reload [POOL_SLOTS];

   mst_pkg::req_type cmd_backlog [$];
   mst_pkg::rsp_type predicted_words [$];
   int      cmds_sent = 0;
   int      cmds_taken = 0;
   int      mismatches = 0;
   int      kind_seen [7] = '{default: 0};
   int      send_gap_pct = 0;
   int      recv_stall_pct = 0;

   task automatic post_expect(input logic [2:0] kind, input int slot, input logic fin);
      mst_pkg::rsp_type w;
      w.kind = kind;
      w.slot = slot[5:0];
      w.now_tick = tick_now;
      w.last = fin;
      predicted_words.push_back(w);
   endtask

   task automatic advance_pool_model(input mst_pkg::req_type w);
      int fired [$];
      int i;
      logic found;
      case (w.cmd)
         mst_pkg::CMD_TICK: begin
            tick_now = tick_now + 32'd1;
            for (i = 0; i < POOL_SLOTS; i++) begin
               if (slot_live[i] && slot_due[i] <= tick_now &&
                   fired.size() < mst_pkg::MAX_RESULTS) begin
                  if (slot_reload[i] != 32'd0)
                     slot_due[i] = tick_now + slot_reload[i];
                  else
                     slot_live[i] = 1'b0;
                  fired.push_back(i);
               end
            end
            if (fired.size() == 0)
               post_expect(mst_pkg::KIND_TICK_NONE, 0, 1'b1);
            for (i = 0; i < fired.size(); i++)
               post_expect(mst_pkg::KIND_FIRED, fired[i], i == fired.size() - 1);
         end
         mst_pkg::CMD_REGISTER: begin
            found = 1'b0;
            for (i = 0; i < POOL_SLOTS && !found; i++) begin
               if (!slot_live[i]) begin
                  slot_due[i] = tick_now + 32'(w.timeout) * 32'(scale_now);
                  slot_reload[i] = 32'(w.period) * 32'(scale_now);
                  slot_live[i] = 1'b1;
                  found = 1'b1;
                  post_expect(mst_pkg::KIND_REGISTERED, i, 1'b1);
               end
            end
            if (!found)
               post_expect(mst_pkg::KIND_FULL, 0, 1'b1);
         end
         mst_pkg::CMD_UNREGISTER: begin
            if (w.slot_index >= POOL_SLOTS) begin
               post_expect(mst_pkg::KIND_BAD_INDEX, 0, 1'b1);
            end else if (!slot_live[w.slot_index]) begin
               post_expect(mst_pkg::KIND_WAS_EMPTY, 0, 1'b1);
            end else begin
               slot_live[w.slot_index] = 1'b0;
               slot_reload[w.slot_index] = 32'd0;
               post_expect(mst_pkg::KIND_FREED, int'(w.slot_index), 1'b1);
            end
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_valid <= 1'b1;
            req_word <= cmd_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor and checker
   always @(posedge clock) begin
      mst_pkg::rsp_type want;
      if (reset) begin
         tick_now = 32'd0;
         scale_now = mst_pkg::TIME_SCALE_RESET;
         for (int i = 0; i < POOL_SLOTS; i++)
            slot_live[i] = 1'b0;
      end else begin
         if (csr_wr_en)
            scale_now = csr_wr_data;
         if (req_valid && req_ready) begin
            cmds_taken++;
            advance_pool_model(req_word);
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_word.kind < 3'd7)
               kind_seen[rsp_word.kind]++;
            if (predicted_words.size() == 0) begin
               $error("unexpected result word %p", rsp_word);
               mismatches++;
            end else begin
               want = predicted_words.pop_front();
               if (rsp_word.kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_word.kind);
                  mismatches++;
               end
               if (rsp_word.slot !== want.slot) begin
                  $error("slot: expected %0d, actual %0d", want.slot, rsp_word.slot);
                  mismatches++;
               end
               if (rsp_word.now_tick !== want.now_tick) begin
                  $error("now_tick: expected %0d, actual %0d", want.now_tick,
                         rsp_word.now_tick);
                  mismatches++;
               end
               if (rsp_word.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_word.last);
                  mismatches++;
               end
            end
         end
      end
   end

   function automatic mst_pkg::req_type mk_cmd(input logic [1:0] cmd, input logic [15:0] tmo,
                                               input logic [15:0] per, input logic [7:0] idx);
      mst_pkg::req_type w;
      w.cmd = cmd;
      w.timeout = tmo;
      w.period = per;
      w.slot_index = idx;
      return w;
   endfunction

   task automatic queue_cmd(input mst_pkg::req_type w);
      cmd_backlog.push_back(w);
      cmds_sent++;
   endtask

   function automatic logic [15:0] pick_timeout();
      int r;
      r = $urandom_range(99);
      if (r < 80) return 16'($urandom_range(4));
      if (r < 95) return 16'($urandom_range(40, 5));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_period();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 16'd0;
      if (r < 85) return 16'($urandom_range(4, 1));
      return 16'($urandom);
   endfunction

   // mostly timer traffic with short timeouts, plus fill bursts and some junk
   task automatic queue_random_phase(input int count);
      int made;
      int r;
      int n;
      made = 0;
      while (made < count) begin
         r = $urandom_range(99);
         if (r < 8) begin
            n = $urandom_range(16, 6);
            repeat (n)
               queue_cmd(mk_cmd(mst_pkg::CMD_REGISTER, 16'($urandom_range(2)),
                                pick_period(), 8'($urandom)));
            made += n;
            n = $urandom_range(6, 2);
            repeat (n)
               queue_cmd(mk_cmd(mst_pkg::CMD_TICK, 16'($urandom), 16'($urandom),
                                8'($urandom)));
            made += n;
         end else if (r < 11) begin
            queue_cmd(mk_cmd(CMD_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom)));
         end else if (r < 56) begin
            queue_cmd(mk_cmd(mst_pkg::CMD_TICK, 16'($urandom), 16'($urandom),
                             8'($urandom)));
            made++;
         end else if (r < 83) begin
            queue_cmd(mk_cmd(mst_pkg::CMD_REGISTER, pick_timeout(), pick_period(),
                             8'($urandom)));
            made++;
         end else begin
            queue_cmd(mk_cmd(mst_pkg::CMD_UNREGISTER, 16'($urandom), 16'($urandom),
                             ($urandom_range(99) < 75) ? 8'($urandom_range(15))
                                                       : 8'($urandom_range(255, 16))));
            made++;
         end
      end
   endtask

   // wait until every word has come back, then give the ring time to finish
   task automatic settle_pool();
      while (!(cmds_taken == cmds_sent && predicted_words.size() == 0))
         @(posedge clock);
      repeat (POOL_SLOTS + 4) @(posedge clock);
   endtask

   task automatic set_time_scale(input logic [3:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 27;
      recv_stall_pct = 55;

      // reset scale of 10
      queue_cmd(mk_cmd(mst_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00));
      queue_cmd(mk_cmd(mst_pkg::CMD_REGISTER, 16'd0, 16'd0, 8'h00));
      queue_cmd(mk_cmd(mst_pkg::CMD_REGISTER, 16'd1, 16'd1, 8'h00));
      queue_cmd(mk_cmd(mst_pkg::CMD_TICK, 16'hffff, 16'hffff, 8'hff));
      queue_cmd(mk_cmd(mst_pkg::CMD_UNREGISTER, 16'd0, 16'd0, 8'hff));
      queue_cmd(mk_cmd(mst_pkg::CMD_UNREGISTER, 16'd0, 16'd0, 8'(POOL_SLOTS)));
      queue_cmd(mk_cmd(mst_pkg::CMD_UNREGISTER, 16'd0, 16'd0, 8'd5));
      queue_cmd(mk_cmd(mst_pkg::CMD_UNREGISTER, 16'd0, 16'd0, 8'd1));
      queue_cmd(mk_cmd(CMD_UNUSED, 16'hffff, 16'hffff, 8'hff));
      queue_cmd(mk_cmd(mst_pkg::CMD_REGISTER, 16'hffff, 16'hffff, 8'h00));
      queue_cmd(mk_cmd(mst_pkg::CMD_UNREGISTER, 16'd0, 16'd0, 8'd0));
      settle_pool();

      // zero scale: every slot due at once, then a full pool, then one tick fires all
      set_time_scale(4'd0);
      repeat (POOL_SLOTS)
         queue_cmd(mk_cmd(mst_pkg::CMD_REGISTER, 16'($urandom), 16'($urandom), 8'h00));
      queue_cmd(mk_cmd(mst_pkg::CMD_REGISTER, 16'd3, 16'd3, 8'h00));
      queue_cmd(mk_cmd(mst_pkg::CMD_TICK, 16'd0, 16'd0, 8'h00));
      settle_pool();

      set_time_scale(4'd1);
      queue_random_phase(95);
      settle_pool();

      send_gap_pct = 55;
      recv_stall_pct = 27;
      set_time_scale(4'd15);
      queue_random_phase(95);
      settle_pool();

      send_gap_pct = 0;
      recv_stall_pct = 0;
      set_time_scale(4'($urandom_range(14, 2)));
      queue_random_phase(95);
      settle_pool();

      $display("covered %0d commands at scales 10, 0, 1, 15 and one in between",
               cmds_taken);
      $display("results: %0d fired, %0d quiet ticks, %0d registered, %0d full, %0d freed",
               kind_seen[mst_pkg::KIND_FIRED], kind_seen[mst_pkg::KIND_TICK_NONE],
               kind_seen[mst_pkg::KIND_REGISTERED], kind_seen[mst_pkg::KIND_FULL],
               kind_seen[mst_pkg::KIND_FREED]);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d words still expected", predicted_words.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
